/* src/plc_pkg.sv */
// Shared types, codes and pulse table math for the priority LED controller.
package plc_pkg;

  // command codes
  localparam logic [1:0] CMD_REQUEST = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_TICK    = 2'd2;

  // pattern codes
  localparam logic [1:0] MODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_SOLID = 2'd1;
  localparam logic [1:0] MODE_BLINK = 2'd2;
  localparam logic [1:0] MODE_PULSE = 2'd3;

  localparam int unsigned FIELD_PRIO_W = 4;
  localparam int unsigned DIV_W        = 32;
  localparam int unsigned DIVISOR_W    = 16;
  localparam int unsigned DIV_CNT_W    = 6;
  localparam int unsigned ROM_W        = 9;

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  prio;
    logic [1:0]  pattern;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
    logic [15:0] period_in;
    logic [31:0] duration_in;
  } in_word_t;

  typedef struct packed {
    logic       accepted;
    logic       timed_out;
    logic [7:0] red_drive;
    logic [7:0] green_drive;
    logic [7:0] blue_drive;
  } out_word_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] steps;
  } div_req_t;

  // Raised-sine entry from the Q30 phase x of the quadrant, Taylor series to x^11.
  function automatic logic [ROM_W-1:0] sine_entry(input logic [63:0] x,
                                                  input logic [1:0]  quad);
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] mag;
    x2  = (x * x) >> 30;
    t   = Q30_ONE - x2 / 64'd110;
    t   = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
    t   = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
    t   = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
    t   = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
    s   = (x * t) >> 30;
    mag = (s * 64'd128 + (64'd1 << 29)) >> 30;
    if (mag > 64'd128) begin
      mag = 64'd128;
    end
    if (quad < 2'd2) begin
      return ROM_W'(64'd128 + mag);
    end
    return ROM_W'(64'd128 - mag);
  endfunction

endpackage

/* src/plc_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle, left-aligned dividend.
module plc_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  plc_pkg::div_req_t              req_i,
  input  logic [plc_pkg::DIV_W-1:0]      dividend_i,
  input  logic [plc_pkg::DIVISOR_W-1:0]  divisor_i,
  output logic                           done_o,
  output logic [plc_pkg::DIV_W-1:0]      quotient_o,
  output logic [plc_pkg::DIVISOR_W-1:0]  remainder_o
);

  logic                              busy_q;
  logic                              done_q;
  logic [plc_pkg::DIV_CNT_W-1:0]     cnt_q;
  logic [plc_pkg::DIV_W-1:0]         quo_q;
  logic [plc_pkg::DIVISOR_W-1:0]     rem_q;
  logic [plc_pkg::DIVISOR_W-1:0]     dvs_q;
  logic [plc_pkg::DIVISOR_W:0]       trial;
  logic                              fits;

  assign trial = {rem_q, quo_q[plc_pkg::DIV_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == plc_pkg::DIV_CNT_W'(1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - plc_pkg::DIV_CNT_W'(1);
        if (cnt_q == plc_pkg::DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      // remainder stays below the divisor, so the difference fits
      rem_q <= fits ? plc_pkg::DIVISOR_W'(trial - {1'b0, dvs_q})
                    : trial[plc_pkg::DIVISOR_W-1:0];
      quo_q <= {quo_q[plc_pkg::DIV_W-2:0], fits};
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

/* src/priority_led_pattern_controller_top.sv */
// Top level of the priority LED pattern controller: owner state, sequencer, pulse table.
//
// Input channel (in_valid_i/in_ready_o, in_word_i) takes request, release and
// one-millisecond tick words; the output channel (out_valid_o/out_ready_i,
// out_word_o) returns exactly one word per input word, in order, carrying the
// accepted and timed_out flags and the LED drive after that word.
// One word is worked on at a time; in_ready_o is high only in the idle state.
// Request, release, unknown commands and ticks that time out or drive off or
// solid go straight from the idle state to the done state. A blink tick runs
// the serial divider for elapsed mod period. A pulse tick then runs it a
// second time for the table index (16 + clog2(SINE_STEPS+1) bits) and reads
// the registered sine table.
// The result sits in an output register, so the next word can be taken while
// a result waits; if the receiver stalls, the following result holds in the
// sequencer until the register frees up.
// Reset clears the owner to idle priority, mode off, colour, period, duration
// and elapsed count to zero, and the drive to off.
module priority_led_pattern_controller_top #(
  parameter int unsigned SINE_STEPS    = 256,
  parameter int unsigned PRIORITY_BITS = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  plc_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output plc_pkg::out_word_t out_word_o
);

  localparam int unsigned HP_W  = (PRIORITY_BITS < plc_pkg::FIELD_PRIO_W) ?
                                  PRIORITY_BITS : plc_pkg::FIELD_PRIO_W;
  localparam int unsigned IDX_W = $clog2(SINE_STEPS);
  localparam int unsigned PROD_W = plc_pkg::DIVISOR_W + $clog2(SINE_STEPS + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MOD  = 3'd1;
  localparam logic [2:0] ST_IDX  = 3'd2;
  localparam logic [2:0] ST_ROM  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  // pulse table, built at elaboration
  logic [plc_pkg::ROM_W-1:0] sine_rom [SINE_STEPS];

  for (genvar g = 0; g < SINE_STEPS; g++) begin : g_rom
    localparam longint unsigned TQ   = 4 * g;
    localparam longint unsigned QUAD = TQ / SINE_STEPS;
    localparam longint unsigned REM  = TQ % SINE_STEPS;
    localparam longint unsigned ARG  = (QUAD == 0 || QUAD == 2) ? REM : SINE_STEPS - REM;
    localparam longint unsigned XQ   = (longint'(plc_pkg::HALF_PI_Q30) * ARG) / SINE_STEPS;
    assign sine_rom[g] = plc_pkg::sine_entry(64'(XQ), 2'(QUAD));
  end

  logic [2:0]                state_q, state_d;
  logic [HP_W-1:0]           prio_q;
  logic [1:0]                mode_q;
  logic [7:0]                red_q, green_q, blue_q;
  logic [15:0]               period_q;
  logic [31:0]               duration_q;
  logic [31:0]               elapsed_q;
  logic [7:0]                drv_r_q, drv_g_q, drv_b_q;
  logic                      acc_q, tmo_q;
  logic                      out_valid_q;
  plc_pkg::out_word_t        out_q;
  logic [plc_pkg::ROM_W-1:0] rom_q;

  logic                      in_fire;
  logic                      out_free;
  logic [HP_W-1:0]           in_prio;
  logic [31:0]               elapsed_inc;
  logic                      timeout;
  logic                      needs_div;
  logic [31:0]               idx_prod;
  plc_pkg::div_req_t         div_req;
  logic [plc_pkg::DIV_W-1:0] div_dividend;
  logic                      div_done;
  logic [plc_pkg::DIV_W-1:0] div_quo;
  logic [plc_pkg::DIVISOR_W-1:0] div_rem;
  logic [16:0]               pr, pg, pb;

  assign in_ready_o  = state_q == ST_IDLE;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign in_prio     = in_word_i.prio[HP_W-1:0];
  assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 32'd1;
  assign timeout     = (duration_q != '0) && (elapsed_inc >= duration_q);
  assign needs_div   = !timeout && (period_q != '0) &&
                       (mode_q == plc_pkg::MODE_BLINK || mode_q == plc_pkg::MODE_PULSE);
  assign idx_prod    = 32'(div_rem) * 32'(SINE_STEPS);

  // start the divider on a blink or pulse tick word, then once more for the pulse index
  always_comb begin
    div_req.start = 1'b0;
    div_req.steps = plc_pkg::DIV_CNT_W'(plc_pkg::DIV_W);
    div_dividend  = elapsed_inc;
    if (in_fire && in_word_i.cmd == plc_pkg::CMD_TICK && needs_div) begin
      div_req.start = 1'b1;
    end else if (state_q == ST_MOD && div_done && mode_q == plc_pkg::MODE_PULSE) begin
      div_req.start = 1'b1;
      div_req.steps = plc_pkg::DIV_CNT_W'(PROD_W);
      div_dividend  = idx_prod << (plc_pkg::DIV_W - PROD_W);
    end
  end

  plc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (div_dividend),
    .divisor_i  (period_q),
    .done_o     (div_done),
    .quotient_o (div_quo),
    .remainder_o(div_rem)
  );

  assign pr = 17'(red_q)   * 17'(rom_q);
  assign pg = 17'(green_q) * 17'(rom_q);
  assign pb = 17'(blue_q)  * 17'(rom_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = (in_word_i.cmd == plc_pkg::CMD_TICK && needs_div) ? ST_MOD : ST_DONE;
        end
      end
      ST_MOD: begin
        if (div_done) begin
          state_d = (mode_q == plc_pkg::MODE_PULSE) ? ST_IDX : ST_DONE;
        end
      end
      ST_IDX: begin
        if (div_done) begin
          state_d = ST_ROM;
        end
      end
      ST_ROM:  state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prio_q      <= '0;
      mode_q      <= plc_pkg::MODE_OFF;
      red_q       <= '0;
      green_q     <= '0;
      blue_q      <= '0;
      period_q    <= '0;
      duration_q  <= '0;
      elapsed_q   <= '0;
      drv_r_q     <= '0;
      drv_g_q     <= '0;
      drv_b_q     <= '0;
      acc_q       <= 1'b0;
      tmo_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            acc_q <= (in_word_i.cmd == plc_pkg::CMD_REQUEST) && (in_prio >= prio_q);
            tmo_q <= (in_word_i.cmd == plc_pkg::CMD_TICK) && timeout;
            case (in_word_i.cmd)
              plc_pkg::CMD_REQUEST: begin
                if (in_prio >= prio_q) begin
                  prio_q     <= in_prio;
                  mode_q     <= in_word_i.pattern;
                  red_q      <= in_word_i.red_in;
                  green_q    <= in_word_i.green_in;
                  blue_q     <= in_word_i.blue_in;
                  period_q   <= in_word_i.period_in;
                  duration_q <= in_word_i.duration_in;
                  elapsed_q  <= '0;
                end
              end
              plc_pkg::CMD_RELEASE: begin
                if (in_prio == prio_q) begin
                  prio_q  <= '0;
                  mode_q  <= plc_pkg::MODE_OFF;
                  drv_r_q <= '0;
                  drv_g_q <= '0;
                  drv_b_q <= '0;
                end
              end
              plc_pkg::CMD_TICK: begin
                elapsed_q <= elapsed_inc;
                if (timeout) begin
                  prio_q  <= '0;
                  mode_q  <= plc_pkg::MODE_OFF;
                  drv_r_q <= '0;
                  drv_g_q <= '0;
                  drv_b_q <= '0;
                end else if (mode_q == plc_pkg::MODE_SOLID) begin
                  drv_r_q <= red_q;
                  drv_g_q <= green_q;
                  drv_b_q <= blue_q;
                end else if (!needs_div) begin
                  // off mode, or blink/pulse with a zero period
                  drv_r_q <= '0;
                  drv_g_q <= '0;
                  drv_b_q <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        ST_MOD: begin
          if (div_done && mode_q == plc_pkg::MODE_BLINK) begin
            // lit for the first half of each period
            if (div_rem < (period_q >> 1)) begin
              drv_r_q <= red_q;
              drv_g_q <= green_q;
              drv_b_q <= blue_q;
            end else begin
              drv_r_q <= '0;
              drv_g_q <= '0;
              drv_b_q <= '0;
            end
          end
        end
        ST_IDX: ;
        ST_ROM: begin
          drv_r_q <= pr[15:8];
          drv_g_q <= pg[15:8];
          drv_b_q <= pb[15:8];
        end
        ST_DONE: ;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDX && div_done) begin
      rom_q <= sine_rom[div_quo[IDX_W-1:0]];
    end
    if (state_q == ST_DONE && out_free) begin
      out_q.accepted    <= acc_q;
      out_q.timed_out   <= tmo_q;
      out_q.red_drive   <= drv_r_q;
      out_q.green_drive <= drv_g_q;
      out_q.blue_drive  <= drv_b_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

/* tb/sv/led_owner_monitor.sv */
// Bench monitor: predicts each LED result word from the accepted input words and compares.
module led_owner_monitor #(
  parameter int unsigned SINE_STEPS = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  plc_pkg::in_word_t  in_word_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  plc_pkg::out_word_t out_word_i,
  output int                 pending_o,
  output int                 errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // owner state as the block should hold it
  logic [3:0]  own_prio;
  logic [1:0]  own_mode;
  logic [7:0]  own_red;
  logic [7:0]  own_green;
  logic [7:0]  own_blue;
  logic [15:0] own_period;
  logic [31:0] own_life;
  logic [31:0] age_ms;
  logic [23:0] led_rgb;

  logic [8:0]         pulse_rom [SINE_STEPS];
  plc_pkg::out_word_t drive_fifo [$];
  int                 err_cnt = 0;

  // sin(pi/2 * a / n) in Q30
  function automatic logic [63:0] sine_q30(input logic [63:0] a, input logic [63:0] n);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    x  = (plc_pkg::HALF_PI_Q30 * a) / n;
    x2 = (x * x) >> 30;
    t  = plc_pkg::Q30_ONE - x2 / 64'd110;
    t  = plc_pkg::Q30_ONE - ((x2 * t) >> 30) / 64'd72;
    t  = plc_pkg::Q30_ONE - ((x2 * t) >> 30) / 64'd42;
    t  = plc_pkg::Q30_ONE - ((x2 * t) >> 30) / 64'd20;
    t  = plc_pkg::Q30_ONE - ((x2 * t) >> 30) / 64'd6;
    return (x * t) >> 30;
  endfunction

  function automatic logic [8:0] raised_sine(input int unsigned idx);
    logic [63:0] n;
    logic [63:0] quad;
    logic [63:0] rem;
    logic [63:0] s;
    logic [63:0] mag;
    n    = 64'(SINE_STEPS);
    quad = (64'(idx) * 64'd4) / n;
    rem  = (64'(idx) * 64'd4) % n;
    s    = (quad == 64'd0 || quad == 64'd2) ? sine_q30(rem, n) : sine_q30(n - rem, n);
    mag  = (s * 64'd128 + (64'd1 << 29)) >> 30;
    if (mag > 64'd128) begin
      mag = 64'd128;
    end
    return (quad < 64'd2) ? 9'(64'd128 + mag) : 9'(64'd128 - mag);
  endfunction

  function automatic logic [7:0] scale(input logic [7:0] c, input logic [8:0] lvl);
    logic [16:0] p;
    p = c * lvl;
    return p[15:8];
  endfunction

  function automatic void drop_owner();
    own_prio = '0;
    own_mode = plc_pkg::MODE_OFF;
    led_rgb  = '0;
  endfunction

  // one millisecond: returns 1 on timeout
  function automatic logic advance_ms();
    logic [31:0] pos;
    logic [63:0] idx;
    logic [8:0]  lvl;
    if (age_ms != '1) begin
      age_ms = age_ms + 32'd1;
    end
    if (own_life != '0 && age_ms >= own_life) begin
      drop_owner();
      return 1'b1;
    end
    case (own_mode)
      plc_pkg::MODE_SOLID: led_rgb = {own_red, own_green, own_blue};
      plc_pkg::MODE_BLINK: begin
        if (own_period == '0) begin
          led_rgb = '0;
        end else begin
          pos     = age_ms % own_period;
          led_rgb = (pos < own_period / 2) ? {own_red, own_green, own_blue} : 24'd0;
        end
      end
      plc_pkg::MODE_PULSE: begin
        if (own_period == '0) begin
          led_rgb = '0;
        end else begin
          pos     = age_ms % own_period;
          idx     = (64'(pos) * 64'(SINE_STEPS)) / own_period;
          lvl     = pulse_rom[idx];
          led_rgb = {scale(own_red, lvl), scale(own_green, lvl), scale(own_blue, lvl)};
        end
      end
      default: led_rgb = '0;
    endcase
    return 1'b0;
  endfunction

  function automatic plc_pkg::out_word_t predict(input plc_pkg::in_word_t w);
    plc_pkg::out_word_t r;
    r = '0;
    case (w.cmd)
      plc_pkg::CMD_REQUEST: begin
        if (w.prio >= own_prio) begin
          own_prio   = w.prio;
          own_mode   = w.pattern;
          own_red    = w.red_in;
          own_green  = w.green_in;
          own_blue   = w.blue_in;
          own_period = w.period_in;
          own_life   = w.duration_in;
          age_ms     = '0;
          r.accepted = 1'b1;
        end
      end
      plc_pkg::CMD_RELEASE: begin
        if (w.prio == own_prio) begin
          drop_owner();
        end
      end
      plc_pkg::CMD_TICK: r.timed_out = advance_ms();
      default: ;
    endcase
    {r.red_drive, r.green_drive, r.blue_drive} = led_rgb;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      err_cnt++;
    end
  endfunction

  initial begin
    for (int i = 0; i < SINE_STEPS; i++) begin
      pulse_rom[i] = raised_sine(i);
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    plc_pkg::out_word_t want;
    if (!rst_ni) begin
      own_prio   = '0;
      own_mode   = plc_pkg::MODE_OFF;
      own_red    = '0;
      own_green  = '0;
      own_blue   = '0;
      own_period = '0;
      own_life   = '0;
      age_ms     = '0;
      led_rgb    = '0;
      drive_fifo.delete();
      pending_o <= 0;
      errors_o  <= err_cnt;
    end else begin
      // retire first: a word taken this edge cannot already have a result
      if (out_valid_i && out_ready_i) begin
        if (drive_fifo.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual %0h",
                   $time, out_word_i);
          err_cnt++;
        end else begin
          want = drive_fifo.pop_front();
          check_field("accepted", 8'(want.accepted), 8'(out_word_i.accepted));
          check_field("timed_out", 8'(want.timed_out), 8'(out_word_i.timed_out));
          check_field("red_drive", want.red_drive, out_word_i.red_drive);
          check_field("green_drive", want.green_drive, out_word_i.green_drive);
          check_field("blue_drive", want.blue_drive, out_word_i.blue_drive);
        end
      end
      if (in_valid_i && in_ready_i) begin
        drive_fifo.push_back(predict(in_word_i));
      end
      pending_o <= drive_fifo.size();
      errors_o  <= err_cnt;
    end
  end

endmodule

/* tb/sv/testbench.sv */
// Bench top for the priority LED controller: clock, reset, stimulus and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam int         RANDOM_WORDS = 600;
  localparam int         CALM_WORDS   = 100;
  localparam int         STALL_LIMIT  = 3000;
  localparam int         DRAIN_CYCLES = 150;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  plc_pkg::in_word_t  in_word   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  plc_pkg::out_word_t out_word;
  int                 pending;
  int                 errors;
  int                 quiet     = 0;
  logic               calm      = 1'b0;
  logic [3:0]         owner_guess = '0;

  always #5ns clk = ~clk;

  priority_led_pattern_controller_top i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_word_o (out_word)
  );

  led_owner_monitor i_monitor (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_i (in_ready),
    .in_word_i  (in_word),
    .out_valid_i(out_valid),
    .out_ready_i(out_ready),
    .out_word_i (out_word),
    .pending_o  (pending),
    .errors_o   (errors)
  );

  // cycles with no word moving on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: stall bursts, none once calm
  initial begin
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  function automatic plc_pkg::in_word_t word_of(input logic [1:0] cmd,
                                                input logic [3:0] prio,
                                                input logic [1:0] pattern,
                                                input logic [23:0] rgb,
                                                input logic [15:0] period,
                                                input logic [31:0] life);
    plc_pkg::in_word_t w;
    w.cmd         = cmd;
    w.prio        = prio;
    w.pattern     = pattern;
    {w.red_in, w.green_in, w.blue_in} = rgb;
    w.period_in   = period;
    w.duration_in = life;
    return w;
  endfunction

  function automatic plc_pkg::in_word_t noise_word();
    logic [95:0] raw;
    raw = {$urandom(), $urandom(), $urandom()};
    return raw[79:0];
  endfunction

  function automatic plc_pkg::in_word_t random_request();
    plc_pkg::in_word_t w;
    int unsigned       roll;
    w     = noise_word();
    w.cmd = plc_pkg::CMD_REQUEST;
    if ($urandom_range(0, 1) == 0) begin
      w.prio = 4'($urandom_range(owner_guess, 15));
    end
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      w.period_in = '0;
    end else if (roll < 80) begin
      w.period_in = 16'($urandom_range(1, 24));
    end else if (roll < 95) begin
      w.period_in = 16'($urandom_range(25, 400));
    end
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      w.duration_in = '0;
    end else if (roll < 85) begin
      w.duration_in = 32'($urandom_range(1, 40));
    end else if (roll < 95) begin
      w.duration_in = '1;
    end
    return w;
  endfunction

  // holds valid high across back-to-back words, drops it only for a gap
  task automatic send_word(input plc_pkg::in_word_t w);
    int gap;
    gap = (!calm && $urandom_range(0, 5) == 0) ? int'($urandom_range(1, 15)) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_word  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_tick();
    send_word(word_of(plc_pkg::CMD_TICK, 4'd0, plc_pkg::MODE_OFF, 24'h0, 16'd0, 32'd0));
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    plc_pkg::in_word_t w;
    int                sent;
    int unsigned       pick;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed
    send_tick();
    send_word(word_of(plc_pkg::CMD_RELEASE, 4'd0, plc_pkg::MODE_OFF, 24'h0, 16'd0, 32'd0));
    send_word(word_of(plc_pkg::CMD_REQUEST, 4'd0, plc_pkg::MODE_SOLID, 24'hFF00AA,
                      16'd0, 32'd0));
    send_tick();
    send_word(word_of(plc_pkg::CMD_REQUEST, 4'd15, plc_pkg::MODE_PULSE, 24'hFFFFFF,
                      16'd1, 32'd0));
    send_tick();
    // lower priority is turned away, release at a foreign priority is ignored
    send_word(word_of(plc_pkg::CMD_REQUEST, 4'd3, plc_pkg::MODE_SOLID, 24'h123456,
                      16'd7, 32'd9));
    send_word(word_of(plc_pkg::CMD_RELEASE, 4'd3, plc_pkg::MODE_OFF, 24'h0, 16'd0, 32'd0));
    send_word(word_of(plc_pkg::CMD_RELEASE, 4'd15, plc_pkg::MODE_OFF, 24'h0, 16'd0, 32'd0));
    send_tick();
    // blink: lit, dark, then timeout twice since the duration stays held
    send_word(word_of(plc_pkg::CMD_REQUEST, 4'd5, plc_pkg::MODE_BLINK, 24'h80C0E0,
                      16'd4, 32'd3));
    repeat (4) send_tick();
    // zero period in blink and pulse
    send_word(word_of(plc_pkg::CMD_REQUEST, 4'd0, plc_pkg::MODE_BLINK, 24'hFFFFFF,
                      16'd0, 32'd0));
    send_tick();
    send_word(word_of(plc_pkg::CMD_REQUEST, 4'd0, plc_pkg::MODE_PULSE, 24'hFFFFFF,
                      16'd0, 32'd0));
    send_tick();
    send_word(word_of(plc_pkg::CMD_REQUEST, 4'd9, plc_pkg::MODE_PULSE, 24'hFF8001,
                      16'hFFFF, 32'hFFFF_FFFF));
    send_tick();
    send_word(word_of(CMD_UNUSED, 4'hF, plc_pkg::MODE_PULSE, 24'hFFFFFF,
                      16'hFFFF, 32'hFFFF_FFFF));
    // equal priority takes over
    send_word(word_of(plc_pkg::CMD_REQUEST, 4'd9, plc_pkg::MODE_PULSE, 24'hFFFFFF,
                      16'd4, 32'd0));
    repeat (4) send_tick();
    owner_guess = 4'd9;
    wait_for_results();

    // random: mostly request-then-ticks, with releases and stray commands
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      calm = (sent >= RANDOM_WORDS - CALM_WORDS);
      pick = $urandom_range(0, 99);
      w    = noise_word();
      if (pick < 20) begin
        w = random_request();
        if (w.prio >= owner_guess) begin
          owner_guess = w.prio;
        end
      end else if (pick < 30) begin
        w.cmd = plc_pkg::CMD_RELEASE;
        if ($urandom_range(0, 3) != 0) begin
          w.prio = owner_guess;
        end
        if (w.prio == owner_guess) begin
          owner_guess = '0;
        end
      end else if (pick < 33) begin
        w.cmd = CMD_UNUSED;
      end else begin
        w.cmd = plc_pkg::CMD_TICK;
      end
      if ($urandom_range(0, 49) == 0) begin
        owner_guess = '0;
      end
      send_word(w);
      if (w.cmd != CMD_UNUSED) begin
        sent++;
      end
      if (!calm && $urandom_range(0, 99) == 0) begin
        wait_for_results();
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* sim.f */
src/plc_pkg.sv
src/plc_div.sv
src/priority_led_pattern_controller_top.sv
tb/sv/led_owner_monitor.sv
tb/sv/testbench.sv
